@@ hdl/kps_pkg.sv @@
// ----------------------------------------------------------------------------
// kps_pkg
// shared constants and types of the matrix keypad scanner
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int NUM_COLUMNS = 4;
  localparam int NUM_ROWS    = 4;

  localparam int COL_W   = $clog2(NUM_COLUMNS);
  localparam int PASS_W  = $clog2(NUM_ROWS + 1);
  localparam int KEY_W   = 5;
  localparam int DEB_W   = 10;
  localparam int POLL_W  = 8;
  localparam int HOLD_W  = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int IN_TW   = 8;
  localparam int OUT_TW  = 16;
  localparam int RES_W   = NUM_ROWS + 1 + KEY_W + 1;

  localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_POLL     = 2'd1;
  localparam logic [IDX_W-1:0] REG_HOLD     = 2'd2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 10'd80;
  localparam logic [POLL_W-1:0] POLL_RESET     = 8'd30;
  localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd5000;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [POLL_W-1:0] poll_ticks;
    logic [HOLD_W-1:0] hold_timeout_ticks;
  } kps_cfg_t;

  typedef struct packed {
    logic                busy_res;
    logic [KEY_W-1:0]    key_index;
    logic                key_valid;
    logic [NUM_ROWS-1:0] row_drive;
  } kps_res_t;

endpackage

@@ hdl/kps_cfg.sv @@
// ----------------------------------------------------------------------------
// kps_cfg
// timing registers of the scanner, written through the plain write port
// ----------------------------------------------------------------------------
module kps_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [kps_pkg::IDX_W-1:0]   cfg_index,
  input  logic [kps_pkg::CFG_W-1:0]   cfg_data,
  output kps_pkg::kps_cfg_t           cfg
);
  import kps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RESET;
      cfg.poll_ticks         <= POLL_RESET;
      cfg.hold_timeout_ticks <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg.debounce_ticks     <= cfg_data[DEB_W-1:0];
        REG_POLL:     cfg.poll_ticks         <= cfg_data[POLL_W-1:0];
        REG_HOLD:     cfg.hold_timeout_ticks <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/kps_fsm.sv @@
// ----------------------------------------------------------------------------
// kps_fsm
// scan, debounce and hold sequencer, advanced by one tick word per step
// ----------------------------------------------------------------------------
module kps_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [kps_pkg::NUM_COLUMNS-1:0] column_levels,
  input  kps_pkg::kps_cfg_t             cfg,
  output kps_pkg::kps_res_t             res
);
  import kps_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SCAN,
    PH_DEBOUNCE,
    PH_HOLD
  } phase_t;

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(NUM_COLUMNS - 1);
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(NUM_ROWS);
  localparam logic [HOLD_W-1:0] HOLD_MAX  = '1;

  phase_t             phase, phase_next;
  logic [PASS_W-1:0]  row_pass, row_pass_next;
  logic [COL_W-1:0]   column_pos, column_pos_next;
  logic [DEB_W-1:0]   wait_count, wait_count_next;
  logic [HOLD_W-1:0]  hold_count, hold_count_next;

  logic               col_low;
  logic [DEB_W-1:0]   wait_inc;
  logic [HOLD_W-1:0]  hold_inc;
  logic               released;
  logic               key_valid;
  logic [KEY_W-1:0]   key_index;
  logic [NUM_ROWS-1:0] row_drive;

  assign col_low  = !column_levels[column_pos];
  assign wait_inc = wait_count + DEB_W'(1);
  assign hold_inc = (hold_count != HOLD_MAX) ? hold_count + HOLD_W'(1) : hold_count;

  always_comb begin
    phase_next      = phase;
    row_pass_next   = row_pass;
    column_pos_next = column_pos;
    wait_count_next = wait_count;
    hold_count_next = hold_count;
    released        = 1'b0;
    key_valid       = 1'b0;
    key_index       = '0;
    case (phase)
      PH_IDLE: begin
        if (column_levels != '1) begin
          phase_next      = PH_SCAN;
          row_pass_next   = '0;
          column_pos_next = '0;
          wait_count_next = '0;
          hold_count_next = '0;
        end
      end
      PH_SCAN, PH_DEBOUNCE: begin
        if (phase == PH_SCAN && col_low) begin
          phase_next      = PH_DEBOUNCE;
          wait_count_next = '0;
        end else if (phase == PH_DEBOUNCE && wait_inc < cfg.debounce_ticks
                     && wait_inc != '0) begin
          wait_count_next = wait_inc;
        end else if (phase == PH_DEBOUNCE && col_low) begin
          phase_next      = PH_HOLD;
          wait_count_next = '0;
          hold_count_next = '0;
        end else begin
          // move on to the next column or pass, or back to idle after the last pass
          wait_count_next = '0;
          if (column_pos != COL_LAST) begin
            column_pos_next = column_pos + COL_W'(1);
            phase_next      = PH_SCAN;
          end else begin
            column_pos_next = '0;
            if (row_pass >= PASS_LAST) begin
              row_pass_next = '0;
              phase_next    = PH_IDLE;
            end else begin
              row_pass_next = row_pass + PASS_W'(1);
              phase_next    = PH_SCAN;
            end
          end
        end
      end
      PH_HOLD: begin
        hold_count_next = hold_inc;
        wait_count_next = wait_inc;
        if (wait_inc >= DEB_W'(cfg.poll_ticks)) begin
          wait_count_next = '0;
          released        = !col_low;
        end
        if (released || hold_inc >= cfg.hold_timeout_ticks) begin
          key_valid = 1'b1;
          if (row_pass == '0) begin
            key_index = KEY_W'(NUM_ROWS * NUM_COLUMNS) + KEY_W'(column_pos);
          end else begin
            key_index = KEY_W'(row_pass - PASS_W'(1)) * KEY_W'(NUM_COLUMNS)
                        + KEY_W'(column_pos);
          end
          phase_next      = PH_IDLE;
          row_pass_next   = '0;
          column_pos_next = '0;
          wait_count_next = '0;
          hold_count_next = '0;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // row levels follow the updated state
  always_comb begin
    if (phase_next == PH_IDLE) begin
      row_drive = '0;
    end else if (row_pass_next == '0 || row_pass_next > PASS_LAST) begin
      row_drive = '1;
    end else begin
      row_drive = ~(NUM_ROWS'(1) << (row_pass_next - PASS_W'(1)));
    end
  end

  always_comb begin
    res.row_drive = row_drive;
    res.key_valid = key_valid;
    res.key_index = key_index;
    res.busy_res  = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      row_pass   <= '0;
      column_pos <= '0;
      wait_count <= '0;
      hold_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      row_pass   <= row_pass_next;
      column_pos <= column_pos_next;
      wait_count <= wait_count_next;
      hold_count <= hold_count_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> row_pass == '0 && column_pos == '0)
    else $error("idle with scan position left over");

  a_pass_range: assert property (@(posedge clk) disable iff (rst)
    row_pass <= PASS_LAST)
    else $error("row pass out of range");

  a_event_ends_scan: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> !res.busy_res && phase == PH_HOLD)
    else $error("key event outside hold or without ending the scan");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> key_index < KEY_W'(NUM_ROWS * NUM_COLUMNS + NUM_COLUMNS))
    else $error("key index out of range");

endmodule

@@ hdl/kps_skid.sv @@
// ----------------------------------------------------------------------------
// kps_skid
// two-word result buffer between the sequencer and the master side
// ----------------------------------------------------------------------------
module kps_skid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  kps_pkg::kps_res_t             push_data,
  output logic                          space,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kps_pkg::OUT_TW-1:0]    m_axis_tdata
);
  import kps_pkg::*;

  kps_res_t   head, tail;
  logic [1:0] count;
  logic       pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign space         = (count != 2'd2);
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = OUT_TW'(head);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        head <= push_data;
      end else begin
        head <= tail;
      end
      if (push && count == 2'd2) begin
        tail <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push)
    else $error("word pushed into full result buffer");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("result buffer count lost a word");

endmodule

@@ hdl/matrix_keypad_scanner.sv @@
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// 4x4 key matrix plus four direct keys, scanned with debounce on a tick stream
// ----------------------------------------------------------------------------
// Each input word is one 1 ms tick carrying the sampled column levels; each
// accepted tick yields exactly one result word with the row levels to drive
// next, a key event flag, the key index and the busy flag. A tick is taken
// every clock cycle: the sequencer updates its state in the cycle of
// acceptance and the result lands in a two-word output buffer, so the input
// only stalls when two results wait unread. The user must write the timing
// registers through the cfg port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [3:0] column_levels, [7:4] zero
  input  logic [kps_pkg::IN_TW-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] row_drive, [4] key_valid, [9:5] key_index, [10] busy_res, [15:11] zero
  output logic [kps_pkg::OUT_TW-1:0]   m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [kps_pkg::IDX_W-1:0]    cfg_index,
  input  logic [kps_pkg::CFG_W-1:0]    cfg_data
);
  import kps_pkg::*;

  kps_cfg_t cfg;
  kps_res_t res;
  logic     step;
  logic     space;

  assign s_axis_tready = space;
  assign step          = s_axis_tvalid && space;

  kps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kps_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .column_levels (s_axis_tdata[NUM_COLUMNS-1:0]),
    .cfg           (cfg),
    .res           (res)
  );

  kps_skid u_skid (
    .clk           (clk),
    .rst           (rst),
    .push          (step),
    .push_data     (res),
    .space         (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
